@@ rtl/core/byte_budget_message_fifo_unit_defines.svh @@
// Assertion macros shared by the byte-budget message FIFO modules.
`ifndef BYTE_BUDGET_MESSAGE_FIFO_UNIT_DEFINES_SVH
`define BYTE_BUDGET_MESSAGE_FIFO_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define BBMF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// Check a property on every clock edge, reset included.
`define BBMF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");
`else
`define BBMF_ASSERT(label, clk, rst, prop)
`define BBMF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

@@ rtl/core/bbmf_pkg.sv @@
// Types, constants and the budget check shared by the message FIFO modules.
package bbmf_pkg;

   localparam int QUEUE_DEPTH   = 256;
   localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int HANDLE_W      = 32;
   localparam int SIZE_W        = 32;
   localparam int BYTES_W       = 40;
   localparam int ENTRY_COUNT_W = 9;
   localparam int REQ_TDATA_W   = 64;
   localparam int RSP_TDATA_W   = 120;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_PROBE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_OVER  = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [SIZE_W-1:0]   size;
   } entry_type;

   typedef struct packed {
      logic exec;
      logic finish;
   } step_ctl_type;

   typedef struct packed {
      status_type         status;
      logic               into_empty;
      logic [HANDLE_W-1:0] out_handle;
      logic [SIZE_W-1:0]   out_size;
      logic               probe_fits;
      logic               push_room;
      logic               queue_empty;
      logic [CNT_W-1:0]    entry_count;
      logic [BYTES_W-1:0]  stored_bytes;
   } result_type;

   // Budget admission without overflow; a zero budget admits everything.
   function automatic logic fits(input logic [SIZE_W-1:0]  budget,
                                 input logic [BYTES_W-1:0] total,
                                 input logic [SIZE_W-1:0]  sz);
      logic [SIZE_W-1:0] room;
      room = budget - sz;
      if (budget == '0) begin
         return 1'b1;
      end
      return (sz <= budget) && (total <= BYTES_W'(room));
   endfunction

endpackage

@@ rtl/core/bbmf_store.sv @@
// Descriptor memory: one write port, one read port with registered data.
module bbmf_store import bbmf_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [PTR_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [PTR_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/bbmf_admit.sv @@
// Budget admission, queue pointers, counters and pending size.
`include "byte_budget_message_fifo_unit_defines.svh"
module bbmf_admit import bbmf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [SIZE_W-1:0]   csr_wdata,
   input  step_ctl_type        ctl,
   input  cmd_type             cmd,
   input  logic [HANDLE_W-1:0] handle,
   input  logic [SIZE_W-1:0]   size,
   input  entry_type           rd_data,
   output logic [PTR_W-1:0]    rd_addr,
   output logic                wr_en,
   output logic [PTR_W-1:0]    wr_addr,
   output entry_type           wr_data,
   output result_type          result
);

   logic [SIZE_W-1:0]   budget_ff, budget_in;
   logic [BYTES_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [PTR_W-1:0]    rptr_ff, rptr_in;
   logic [PTR_W-1:0]    wptr_ff, wptr_in;
   logic [SIZE_W-1:0]   pending_ff, pending_in;

   status_type          status_ff, status_in;
   logic                into_empty_ff, into_empty_in;
   logic [HANDLE_W-1:0] out_handle_ff, out_handle_in;
   logic [SIZE_W-1:0]   out_size_ff, out_size_in;
   logic                probe_ff, probe_in;

   logic [SIZE_W-1:0]   chk;
   logic                chk_fits;
   logic [BYTES_W:0]    sum_ext;
   logic [BYTES_W-1:0]  pop_size;
   logic                pend_fits;
   logic                one_fits;

   assign chk       = (budget_ff != '0 && size == '0) ? SIZE_W'(1) : size;
   assign chk_fits  = fits(budget_ff, total_ff, chk);
   assign sum_ext   = {1'b0, total_ff} + (BYTES_W + 1)'(size);
   assign pop_size  = BYTES_W'(rd_data.size);
   assign pend_fits = fits(budget_ff, total_ff, pending_ff);
   assign one_fits  = fits(budget_ff, total_ff, SIZE_W'(1));

   assign rd_addr        = rptr_ff;
   assign wr_addr        = wptr_ff;
   assign wr_data.handle = handle;
   assign wr_data.size   = size;

   always_comb begin
      budget_in     = budget_ff;
      total_in      = total_ff;
      occ_in        = occ_ff;
      rptr_in       = rptr_ff;
      wptr_in       = wptr_ff;
      pending_in    = pending_ff;
      status_in     = status_ff;
      into_empty_in = into_empty_ff;
      out_handle_in = out_handle_ff;
      out_size_in   = out_size_ff;
      probe_in      = probe_ff;
      wr_en         = 1'b0;

      if (csr_we) begin
         budget_in = csr_wdata;
         if (pending_ff != '0 && fits(csr_wdata, total_ff, pending_ff)) begin
            pending_in = '0;
         end
      end

      if (ctl.exec) begin
         status_in     = ST_OK;
         into_empty_in = 1'b0;
         out_handle_in = '0;
         out_size_in   = '0;
         probe_in      = 1'b0;
         case (cmd)
            CMD_PUSH: begin
               if (!chk_fits) begin
                  if (budget_ff != '0) begin
                     pending_in = chk;
                  end
                  status_in = ST_OVER;
               end else if (occ_ff == CNT_W'(QUEUE_DEPTH) || sum_ext[BYTES_W]) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  into_empty_in = (occ_ff == '0);
                  wptr_in       = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
                  occ_in        = occ_ff + 1'b1;
                  total_in      = sum_ext[BYTES_W-1:0];
               end
            end
            CMD_POP: begin
               if (occ_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  out_handle_in = rd_data.handle;
                  out_size_in   = rd_data.size;
                  rptr_in       = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
                  occ_in        = occ_ff - 1'b1;
                  total_in      = (total_ff >= pop_size) ? total_ff - pop_size : '0;
               end
            end
            CMD_PROBE: begin
               probe_in = chk_fits;
            end
            default: begin
            end
         endcase
      end

      // drop the pending size once it fits the updated total
      if (ctl.finish && pending_ff != '0 && pend_fits) begin
         pending_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff  <= '0;
         total_ff   <= '0;
         occ_ff     <= '0;
         rptr_ff    <= '0;
         wptr_ff    <= '0;
         pending_ff <= '0;
      end else begin
         budget_ff  <= budget_in;
         total_ff   <= total_in;
         occ_ff     <= occ_in;
         rptr_ff    <= rptr_in;
         wptr_ff    <= wptr_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      into_empty_ff <= into_empty_in;
      out_handle_ff <= out_handle_in;
      out_size_ff   <= out_size_in;
      probe_ff      <= probe_in;
   end

   always_comb begin
      result.status       = status_ff;
      result.into_empty   = into_empty_ff;
      result.out_handle   = out_handle_ff;
      result.out_size     = out_size_ff;
      result.probe_fits   = probe_ff;
      result.push_room    = (pending_ff != '0 && !pend_fits) ? 1'b0 : one_fits;
      result.queue_empty  = (occ_ff == '0);
      result.entry_count  = occ_ff;
      result.stored_bytes = total_ff;
   end

   `BBMF_ASSERT(a_occ_bound, clock, reset, occ_ff <= CNT_W'(QUEUE_DEPTH))
   `BBMF_ASSERT(a_empty_no_bytes, clock, reset, (occ_ff == '0) |-> (total_ff == '0))
   `BBMF_ASSERT(a_pending_budget, clock, reset, (pending_ff != '0) |-> (budget_ff != '0))
   `BBMF_ASSERT(a_write_in_exec, clock, reset, wr_en |-> (ctl.exec && occ_ff != CNT_W'(QUEUE_DEPTH)))

endmodule

@@ rtl/core/byte_budget_message_fifo_unit.sv @@
// After an accept, a request passes the execute then finish states before response valid.
// A new request is taken only in idle, after the last one has finished; the descriptor
// memory's registered read and the two-step update of byte total then pending size need both states.
// A waiting response does not block the next accept; finish holds only while the
// response register is still occupied. Synchronous active-high reset clears pointers,
// counters, budget and pending size; the descriptor memory is not cleared.
`include "byte_budget_message_fifo_unit_defines.svh"
module byte_budget_message_fifo_unit import bbmf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,  // cmd
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // msg_handle, body_size
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [1:0]             rsp_tuser,  // status
   // into_empty, out_handle, out_size, probe_fits, push_room, queue_empty,
   // entry_count, stored_bytes, zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [SIZE_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   result_type          rsp_ff, rsp_in;

   step_ctl_type        ctl;
   result_type          result;
   entry_type           rd_data;
   entry_type           wr_data;
   logic [PTR_W-1:0]    rd_addr;
   logic [PTR_W-1:0]    wr_addr;
   logic                wr_en;
   logic                req_accept;
   logic                csr_accept;
   logic                rsp_free;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_accept = csr_valid && csr_ready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   assign ctl.exec   = (state_ff == S_EXEC);
   assign ctl.finish = (state_ff == S_FINISH) && rsp_free;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      size_in       = size_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_in        = rsp_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in    = cmd_type'(req_tuser);
               handle_in = req_tdata[HANDLE_W-1:0];
               size_in   = req_tdata[HANDLE_W +: SIZE_W];
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hold until the response register frees up
            if (rsp_free) begin
               rsp_in        = result;
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff    <= cmd_in;
      handle_ff <= handle_in;
      size_ff   <= size_in;
      rsp_ff    <= rsp_in;
   end

   bbmf_admit u_admit (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_accept),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .cmd       (cmd_ff),
      .handle    (handle_ff),
      .size      (size_ff),
      .rd_data   (rd_data),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .result    (result)
   );

   bbmf_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {3'b000,
                        rsp_ff.stored_bytes,
                        ENTRY_COUNT_W'(rsp_ff.entry_count),
                        rsp_ff.queue_empty,
                        rsp_ff.push_room,
                        rsp_ff.probe_fits,
                        rsp_ff.out_size,
                        rsp_ff.out_handle,
                        rsp_ff.into_empty};

   `BBMF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_tvalid_ff))
   `BBMF_ASSERT(a_accept_exec, clock, reset, req_accept |=> (state_ff == S_EXEC))
   `BBMF_ASSERT(a_exec_finish, clock, reset, (state_ff == S_EXEC) |=> (state_ff == S_FINISH))
   `BBMF_ASSERT(a_finish_rsp, clock, reset, ctl.finish |=> (state_ff == S_IDLE && rsp_tvalid_ff))

endmodule
